// ===== src/multichannel_pattern_debouncer_core_assert.svh =====
// Assertion macros for the multichannel pattern debouncer.
`ifndef MULTICHANNEL_PATTERN_DEBOUNCER_CORE_ASSERT_SVH
`define MULTICHANNEL_PATTERN_DEBOUNCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MPD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MPD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/mpd_pkg.sv =====
// Shared types and constants of the multichannel pattern debouncer.
package mpd_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int WINDOW_DEF   = 16;
  localparam int SUMMARY_W    = 8;
  localparam int PINS_W       = 8;
  localparam int CHANNEL_W    = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEVEL = 2'd1,
    OP_RISE  = 2'd2,
    OP_FALL  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [PINS_W-1:0]      pin_samples;
    logic [CHANNEL_W-1:0]   channel;
  } item_t;

  typedef struct packed {
    logic                   queried_bit;
    logic [SUMMARY_W-1:0]   levels;
    logic [SUMMARY_W-1:0]   rising_pending;
    logic [SUMMARY_W-1:0]   falling_pending;
  } result_t;

  // Command broadcast to every lane and to the merging stage.
  typedef struct packed {
    logic                   en;
    opcode_t                opcode;
    logic [CHANNEL_W-1:0]   channel;
  } cmd_t;

  // What one lane reports: present state and the state after this command.
  typedef struct packed {
    logic level;
    logic rise;
    logic fall;
    logic level_next;
    logic rise_next;
    logic fall_next;
  } lane_stat_t;

endpackage

// ===== src/mpd_lane.sv =====
// One debouncer lane: sample history, level and edge flags of a single channel.
module mpd_lane #(
  parameter int WINDOW  = mpd_pkg::WINDOW_DEF,
  parameter int LANE_ID = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  mpd_pkg::cmd_t      cmd,
  input  logic               sample,
  output mpd_pkg::lane_stat_t stat
);

  localparam logic [WINDOW-1:0] HIST_ON  = {1'b0, {(WINDOW-1){1'b1}}};
  localparam logic [WINDOW-1:0] HIST_OFF = {1'b1, {(WINDOW-1){1'b0}}};

  logic [WINDOW-1:0] hist;
  logic [WINDOW-1:0] hist_next;
  logic              level;
  logic              rise;
  logic              fall;
  logic              level_next;
  logic              rise_next;
  logic              fall_next;
  logic              sel;

  assign hist_next = {hist[WINDOW-2:0], sample};
  assign sel       = (int'(cmd.channel) == LANE_ID);

  always_comb begin
    level_next = level;
    rise_next  = rise;
    fall_next  = fall;
    unique case (cmd.opcode)
      mpd_pkg::OP_TICK: begin
        if (hist_next == HIST_ON) begin
          level_next = 1'b1;
          rise_next  = 1'b1;
        end else if (hist_next == HIST_OFF) begin
          level_next = 1'b0;
          fall_next  = 1'b1;
        end
      end
      mpd_pkg::OP_LEVEL: begin
      end
      mpd_pkg::OP_RISE: begin
        if (sel) begin
          rise_next = 1'b0;
        end
      end
      mpd_pkg::OP_FALL: begin
        if (sel) begin
          fall_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= '0;
      level <= 1'b0;
      rise  <= 1'b0;
      fall  <= 1'b0;
    end else if (cmd.en) begin
      if (cmd.opcode == mpd_pkg::OP_TICK) begin
        hist <= hist_next;
      end
      level <= level_next;
      rise  <= rise_next;
      fall  <= fall_next;
    end
  end

  assign stat.level      = level;
  assign stat.rise       = rise;
  assign stat.fall       = fall;
  assign stat.level_next = level_next;
  assign stat.rise_next  = rise_next;
  assign stat.fall_next  = fall_next;

endmodule

// ===== src/mpd_merge.sv =====
// Merging stage: gathers lane state into one result and holds it in an output skid pair.
module mpd_merge #(
  parameter int CHANNELS = mpd_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mpd_pkg::cmd_t       cmd,
  input  mpd_pkg::lane_stat_t stat [CHANNELS],
  output logic                hold,
  output logic                result_valid,
  input  logic                result_stall,
  output mpd_pkg::result_t    result
);

  mpd_pkg::result_t d;
  mpd_pkg::result_t out_data;
  mpd_pkg::result_t skid_data;
  logic             out_valid;
  logic             skid_valid;
  logic             level_q;
  logic             rise_q;
  logic             fall_q;
  logic             taken;

  always_comb begin
    level_q = 1'b0;
    rise_q  = 1'b0;
    fall_q  = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(cmd.channel) == i) begin
        level_q = stat[i].level;
        rise_q  = stat[i].rise;
        fall_q  = stat[i].fall;
      end
    end
  end

  always_comb begin
    d = '0;
    unique case (cmd.opcode)
      mpd_pkg::OP_TICK:  d.queried_bit = 1'b0;
      mpd_pkg::OP_LEVEL: d.queried_bit = level_q;
      mpd_pkg::OP_RISE:  d.queried_bit = rise_q;
      mpd_pkg::OP_FALL:  d.queried_bit = fall_q;
      default:           d.queried_bit = 1'b0;
    endcase
    // Only the first eight channels appear in the summary fields.
    for (int i = 0; i < CHANNELS && i < mpd_pkg::SUMMARY_W; i++) begin
      d.levels[i]          = stat[i].level_next;
      d.rising_pending[i]  = stat[i].rise_next;
      d.falling_pending[i] = stat[i].fall_next;
    end
  end

  assign taken = out_valid && !result_stall;

  // A new transfer arrives only while the skid register is empty, so order is kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (taken) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (cmd.en) begin
        out_data <= d;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (cmd.en) begin
      if (out_valid) begin
        skid_data  <= d;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= d;
        out_valid <= 1'b1;
      end
    end
  end

  assign hold         = skid_valid;
  assign result_valid = out_valid;
  assign result       = out_data;

endmodule

// ===== src/multichannel_pattern_debouncer_core.sv =====
// Multichannel pattern debouncer, top level.
// Each result is registered, in the output entry or, while that is full, in the skid entry.
// Throughput: one item per cycle unless stalled; lanes compare histories combinationally.
// A two-entry output register and skid pair accepts one more item while a result waits.
// Synchronous reset clears histories, levels, flags, the invert mask and both output valid flags.
`include "multichannel_pattern_debouncer_core_assert.svh"
module multichannel_pattern_debouncer_core #(
  parameter int CHANNELS = mpd_pkg::CHANNELS_DEF,
  parameter int WINDOW   = mpd_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  mpd_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output mpd_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpd_pkg::PINS_W-1:0]    cfg_data
);

  logic [mpd_pkg::PINS_W-1:0] invert_mask;
  logic                       accept;
  mpd_pkg::cmd_t              cmd;
  mpd_pkg::lane_stat_t        stat [CHANNELS];
  logic [CHANNELS-1:0]        rise_now;
  logic                       take_rise0;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      invert_mask <= cfg_data;
    end
  end

  assign accept      = item_valid && !item_stall;
  assign cmd.en      = accept;
  assign cmd.opcode  = item.opcode;
  assign cmd.channel = item.channel;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic sample;
    // Channels past the pin field see a constant low sample.
    if (i < mpd_pkg::PINS_W) begin : g_pin
      assign sample = item.pin_samples[i] ^ invert_mask[i];
    end else begin : g_nopin
      assign sample = 1'b0;
    end

    mpd_lane #(
      .WINDOW  (WINDOW),
      .LANE_ID (i)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .sample (sample),
      .stat   (stat[i])
    );

    assign rise_now[i] = stat[i].rise;
  end

  mpd_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .hold         (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign take_rise0 = accept && item.opcode == mpd_pkg::OP_RISE && item.channel == '0;

  `MPD_ASSERT_IMP(a_skid_behind_out, clk, rst, item_stall, result_valid, "skid without output")
  `MPD_ASSERT_NXT(a_accept_gives_result, clk, rst, accept, result_valid, "result lost")
  `MPD_ASSERT_NXT(a_take_clears_rise, clk, rst, take_rise0, !rise_now[0], "rise not cleared")

endmodule

// ===== tb/sv/multichannel_pattern_debouncer_core_tb.sv =====
// Self-checking testbench for the multichannel pattern debouncer core.
`timescale 1ns / 1ps

module multichannel_pattern_debouncer_core_tb;

  localparam logic [15:0] ON_PATTERN  = 16'h7FFF;
  localparam logic [15:0] OFF_PATTERN = 16'h8000;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_PCT    = 34;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       item_valid;
  logic                       item_stall;
  mpd_pkg::item_t             item;
  logic                       result_valid;
  logic                       result_stall;
  mpd_pkg::result_t           result;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [mpd_pkg::PINS_W-1:0] cfg_data;

  // Shadow of the debouncer state, advanced on every accepted transfer.
  logic [15:0]      hist_q [8];
  logic [7:0]       level_q;
  logic [7:0]       rise_q;
  logic [7:0]       fall_q;
  logic [7:0]       mask_q;

  mpd_pkg::result_t pending_results [$];
  int               mismatch_count;
  bit               idle_en;
  bit               hold_pending;

  // Per-channel pulse trains used to build well-formed debounce sequences.
  logic [7:0]       train_lvl;
  int               run_left [8];

  multichannel_pattern_debouncer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic mpd_pkg::result_t debounce_predict(mpd_pkg::item_t it);
    mpd_pkg::result_t r;
    logic [15:0]      h;
    r = '0;
    if (it.opcode == mpd_pkg::OP_TICK) begin
      for (int i = 0; i < 8; i++) begin
        h = {hist_q[i][14:0], it.pin_samples[i] ^ mask_q[i]};
        hist_q[i] = h;
        if (h == ON_PATTERN) begin
          level_q[i] = 1'b1;
          rise_q[i]  = 1'b1;
        end else if (h == OFF_PATTERN) begin
          level_q[i] = 1'b0;
          fall_q[i]  = 1'b1;
        end
      end
    end else begin
      case (it.opcode)
        mpd_pkg::OP_LEVEL: r.queried_bit = level_q[it.channel];
        mpd_pkg::OP_RISE: begin
          r.queried_bit = rise_q[it.channel];
          rise_q[it.channel] = 1'b0;
        end
        default: begin
          r.queried_bit = fall_q[it.channel];
          fall_q[it.channel] = 1'b0;
        end
      endcase
    end
    r.levels          = level_q;
    r.rising_pending  = rise_q;
    r.falling_pending = fall_q;
    return r;
  endfunction

  task automatic report_field(input string fname, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // Results are checked before the prediction for this edge's input transfer,
  // since a result never belongs to an item accepted at the same edge.
  always @(posedge clk) begin : result_check
    mpd_pkg::result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, result);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("queried_bit", {7'd0, want.queried_bit}, {7'd0, result.queried_bit});
          report_field("levels", want.levels, result.levels);
          report_field("rising_pending", want.rising_pending, result.rising_pending);
          report_field("falling_pending", want.falling_pending, result.falling_pending);
        end
      end
      // An item transferred at this edge still sees the old mask.
      if (item_valid && !item_stall) pending_results.push_back(debounce_predict(item));
      if (cfg_valid && cfg_ready) mask_q = cfg_data;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_left = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so the next call either replaces or drops the item.
  task automatic send_item(input mpd_pkg::item_t it);
    while (idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic send_tick(input logic [7:0] pins);
    mpd_pkg::item_t it;
    it.opcode      = mpd_pkg::OP_TICK;
    it.pin_samples = pins;
    it.channel     = 3'($urandom_range(0, 7));
    send_item(it);
  endtask

  task automatic send_query(input mpd_pkg::opcode_t op, input logic [2:0] ch);
    mpd_pkg::item_t it;
    it.opcode      = op;
    it.pin_samples = 8'($urandom_range(0, 255));
    it.channel     = ch;
    send_item(it);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_mask(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Each channel holds a level for a run; long runs make edges, short ones
  // are glitches that the filter must reject.
  function automatic logic [7:0] next_train_pins();
    for (int i = 0; i < 8; i++) begin
      if (run_left[i] == 0) begin
        train_lvl[i] = ~train_lvl[i];
        run_left[i] = ($urandom_range(0, 99) < 60) ? $urandom_range(15, 20)
                                                   : $urandom_range(1, 14);
      end
      run_left[i]--;
    end
    return train_lvl;
  endfunction

  task automatic run_random(input int count);
    logic [7:0]       pins;
    mpd_pkg::opcode_t op;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        pins = next_train_pins();
        if ($urandom_range(0, 99) < 8) pins ^= 8'($urandom_range(0, 255));
        send_tick(pins);
      end else begin
        case ($urandom_range(0, 2))
          0:       op = mpd_pkg::OP_LEVEL;
          1:       op = mpd_pkg::OP_RISE;
          default: op = mpd_pkg::OP_FALL;
        endcase
        send_query(op, 3'($urandom_range(0, 7)));
      end
    end
  endtask

  // Queries straight after reset, then a clean rising edge on every channel.
  task automatic test_directed_edges();
    send_query(mpd_pkg::OP_FALL, 3'd0);
    send_tick(8'h00);
    repeat (15) send_tick(8'hFF);
    send_query(mpd_pkg::OP_LEVEL, 3'd7);
    send_query(mpd_pkg::OP_RISE, 3'd0);
    send_query(mpd_pkg::OP_RISE, 3'd0);
    send_query(mpd_pkg::OP_FALL, 3'd7);
    send_tick(8'hFF);
    wait_idle();
  endtask

  task automatic test_invert_mask();
    logic [7:0] masks [4];
    masks = '{8'hFF, 8'h00, 8'hA5, 8'h00};
    masks[3] = 8'($urandom_range(0, 255));
    foreach (masks[m]) begin
      write_mask(masks[m]);
      run_random(320);
      wait_idle();
    end
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    run_random(300);
    wait_idle();
    idle_en = 1'b1;
  endtask

  // The sink holds off while items keep coming, so the core fills and stalls.
  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_pending = 1'b1;
    run_random(40);
    wait_idle();
    idle_en = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_en = 1'b1;
    hold_pending = 1'b0;
    mismatch_count = 0;
    train_lvl = '0;
    foreach (run_left[i]) run_left[i] = 0;
    foreach (hist_q[i]) hist_q[i] = '0;
    level_q = '0;
    rise_q = '0;
    fall_q = '0;
    mask_q = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_edges();
    test_backpressure();
    test_invert_mask();
    test_full_rate();
    write_mask(8'h3C);
    run_random(260);
    wait_idle();

    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
